// ===== rtl/core/ppd_pkg.sv =====
// Shared types, constants and helpers for the plane deflector.
package ppd_pkg;

   localparam int FRAC_BITS       = 30;
   localparam int DIV_STEPS       = FRAC_BITS + 1;
   localparam int WIDE            = 56;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [2:0] REG_POINT_X  = 3'd0;
   localparam logic [2:0] REG_POINT_Y  = 3'd1;
   localparam logic [2:0] REG_POINT_Z  = 3'd2;
   localparam logic [2:0] REG_NORMAL_X = 3'd3;
   localparam logic [2:0] REG_NORMAL_Y = 3'd4;
   localparam logic [2:0] REG_NORMAL_Z = 3'd5;
   localparam logic [2:0] REG_BOUNCE   = 3'd6;

   typedef struct packed {
      logic [2:0][31:0] point;
      logic [2:0][17:0] normal;
      logic [16:0]      bounce;
   } cfg_type;

   typedef struct packed {
      logic [2:0][31:0] pos;
      logic [2:0][31:0] vel;
      logic [2:0][31:0] disp;
      logic [WIDE-1:0]  a;
      logic [WIDE-1:0]  den;
      logic [35:0]      w;
      logic             hit;
   } item_type;

   function automatic logic [31:0] sat32(input logic signed [63:0] x);
      logic [31:0] r;
      if (x > 64'sd2147483647) begin
         r = 32'h7fff_ffff;
      end else if (x < -64'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/ppd_front.sv =====
// Front pipeline: displacement, plane distances, crossing test, divisor.
module ppd_front (
   input  logic               clock,
   input  logic               reset,
   input  ppd_pkg::cfg_type   cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [2:0][31:0]   in_pos,
   input  logic [2:0][31:0]   in_vel,
   input  logic [30:0]        in_tstep,
   output logic               out_valid,
   input  logic               out_ready,
   output ppd_pkg::item_type  out_item
);
   import ppd_pkg::*;

   logic             adv;
   logic             v1_ff, v2_ff, v3_ff, v4_ff;
   logic [2:0][31:0] pos1_ff, vel1_ff, pos2_ff, vel2_ff, pos3_ff, vel3_ff;
   logic [2:0][62:0] prod1_ff, prod1_in;
   logic [2:0][32:0] diff1_ff, diff1_in;
   logic [2:0][31:0] disp2_ff, disp2_in, disp3_ff;
   logic [2:0][50:0] ma2_ff, ma2_in;
   logic [2:0][49:0] vn2_ff, vn2_in;
   logic [WIDE-1:0]  a3_ff, a3_in;
   logic [2:0][49:0] nd3_ff, nd3_in;
   logic [51:0]      vns3_ff, vns3_in;
   item_type         item4_ff, item4_in;

   assign adv       = !v4_ff || out_ready;
   assign in_ready  = adv;
   assign out_valid = v4_ff;
   assign out_item  = item4_ff;

   always_comb begin
      logic signed [62:0] sh;
      logic signed [WIDE-1:0] sa, snd, e;
      logic signed [51:0] svn;
      sa  = '0;
      snd = '0;
      svn = '0;
      for (int i = 0; i < 3; i++) begin
         prod1_in[i] = 63'($signed(in_vel[i]) * $signed({1'b0, in_tstep}));
         diff1_in[i] = 33'($signed(in_pos[i]) - $signed(cfg.point[i]));
         sh          = $signed(prod1_ff[i]) >>> 16;
         disp2_in[i] = sat32(64'(sh));
         ma2_in[i]   = 51'($signed(cfg.normal[i]) * $signed(diff1_ff[i]));
         vn2_in[i]   = 50'($signed(vel1_ff[i]) * $signed(cfg.normal[i]));
         nd3_in[i]   = 50'($signed(cfg.normal[i]) * $signed(disp2_ff[i]));
         sa  = sa + WIDE'($signed(ma2_ff[i]));
         svn = svn + 52'($signed(vn2_ff[i]));
         snd = snd + WIDE'($signed(nd3_ff[i]));
      end
      a3_in   = sa;
      vns3_in = svn;
      e       = $signed(a3_ff) + snd;
      item4_in.pos  = pos3_ff;
      item4_in.vel  = vel3_ff;
      item4_in.disp = disp3_ff;
      item4_in.a    = a3_ff;
      item4_in.den  = -snd;
      item4_in.w    = 36'($signed(vns3_ff) >>> 16);
      item4_in.hit  = (e <= 0) && ($signed(a3_ff) > 0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pos1_ff  <= in_pos;
         vel1_ff  <= in_vel;
         prod1_ff <= prod1_in;
         diff1_ff <= diff1_in;
         pos2_ff  <= pos1_ff;
         vel2_ff  <= vel1_ff;
         disp2_ff <= disp2_in;
         ma2_ff   <= ma2_in;
         vn2_ff   <= vn2_in;
         pos3_ff  <= pos2_ff;
         vel3_ff  <= vel2_ff;
         disp3_ff <= disp2_ff;
         a3_ff    <= a3_in;
         nd3_ff   <= nd3_in;
         vns3_ff  <= vns3_in;
         item4_ff <= item4_in;
      end
   end

endmodule

// ===== rtl/core/ppd_queue.sv =====
// Small FIFO between the front and back pipelines.
module ppd_queue #(
   parameter int DEPTH = ppd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  ppd_pkg::item_type  push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output ppd_pkg::item_type  pop_item
);
   import ppd_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   item_type        mem [DEPTH];
   logic [IW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            push, pop;

   assign push_ready = cnt_ff != CW'(DEPTH);
   assign pop_valid  = cnt_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = mem[rd_ff];

   always_comb begin
      wr_in  = (push) ? ((wr_ff == IW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = (pop) ? ((rd_ff == IW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/core/ppd_back.sv =====
// Back pipeline: crossing fraction divider, deflection and saturation.
module ppd_back (
   input  logic               clock,
   input  logic               reset,
   input  ppd_pkg::cfg_type   cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  ppd_pkg::item_type  in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [2:0][31:0]   out_pos,
   output logic [2:0][31:0]   out_vel,
   output logic               out_hit
);
   import ppd_pkg::*;

   logic                   adv;
   logic                   dv_ff [DIV_STEPS];
   item_type               it_ff [DIV_STEPS];
   logic [WIDE-1:0]        rem_ff [DIV_STEPS];
   logic [WIDE-1:0]        rem_in [DIV_STEPS];
   logic [DIV_STEPS-1:0]   quo_ff [DIV_STEPS];
   logic [DIV_STEPS-1:0]   quo_in [DIV_STEPS];
   logic                   v1_ff, v2_ff, vo_ff;
   item_type               it1_ff, it2_ff;
   logic [2:0][33:0]       p1_ff, p1_in, p2_ff;
   logic [2:0][38:0]       wn1_ff, wn1_in;
   logic [2:0][52:0]       t2_ff, t2_in;
   logic [2:0][39:0]       r2_ff, r2_in;
   logic [2:0][31:0]       pos_ff, pos_in, vel_ff, vel_in;
   logic                   hit_ff;

   assign adv       = !vo_ff || out_ready;
   assign in_ready  = adv;
   assign out_valid = vo_ff;
   assign out_pos   = pos_ff;
   assign out_vel   = vel_ff;
   assign out_hit   = hit_ff;

   // restoring division, one quotient bit per stage
   always_comb begin
      logic [WIDE-1:0] r2;
      logic            ge;
      ge        = in_item.a >= in_item.den;
      rem_in[0] = ge ? in_item.a - in_item.den : in_item.a;
      quo_in[0] = DIV_STEPS'(ge);
      for (int k = 1; k < DIV_STEPS; k++) begin
         r2        = rem_ff[k-1] << 1;
         ge        = r2 >= it_ff[k-1].den;
         rem_in[k] = ge ? r2 - it_ff[k-1].den : r2;
         quo_in[k] = {quo_ff[k-1][DIV_STEPS-2:0], ge};
      end
   end

   always_comb begin
      logic signed [63:0] pf;
      logic signed [53:0] wn;
      logic signed [57:0] rb;
      logic signed [63:0] np, nv;
      for (int i = 0; i < 3; i++) begin
         pf        = $signed(it_ff[DIV_STEPS-1].disp[i])
                     * $signed({1'b0, quo_ff[DIV_STEPS-1]});
         p1_in[i]  = 34'(pf >>> FRAC_BITS);
         wn        = $signed(it_ff[DIV_STEPS-1].w) * $signed(cfg.normal[i]);
         wn1_in[i] = 39'(wn >>> 15);
         t2_in[i]  = 53'(35'($signed(p1_ff[i]) - $signed(it1_ff.disp[i]))
                     * $signed({1'b0, cfg.bounce}));
         r2_in[i]  = 40'($signed(it1_ff.vel[i]) - $signed(wn1_ff[i]));
         rb        = $signed(r2_ff[i]) * $signed({1'b0, cfg.bounce});
         nv        = 64'(rb >>> 16);
         np        = 64'($signed(it2_ff.pos[i])) + 64'($signed(p2_ff[i]))
                     + 64'($signed(t2_ff[i]) >>> 16);
         pos_in[i] = it2_ff.hit ? sat32(np) : it2_ff.pos[i];
         vel_in[i] = it2_ff.hit ? sat32(nv) : it2_ff.vel[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_STEPS; k++) begin
            dv_ff[k] <= 1'b0;
         end
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else if (adv) begin
         dv_ff[0] <= in_valid;
         for (int k = 1; k < DIV_STEPS; k++) begin
            dv_ff[k] <= dv_ff[k-1];
         end
         v1_ff <= dv_ff[DIV_STEPS-1];
         v2_ff <= v1_ff;
         vo_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         it_ff[0] <= in_item;
         for (int k = 1; k < DIV_STEPS; k++) begin
            it_ff[k] <= it_ff[k-1];
         end
         for (int k = 0; k < DIV_STEPS; k++) begin
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
         end
         it1_ff <= it_ff[DIV_STEPS-1];
         p1_ff  <= p1_in;
         wn1_ff <= wn1_in;
         it2_ff <= it1_ff;
         p2_ff  <= p1_ff;
         t2_ff  <= t2_in;
         r2_ff  <= r2_in;
         pos_ff <= pos_in;
         vel_ff <= vel_in;
         hit_ff <= it2_ff.hit;
      end
   end

endmodule

// ===== rtl/core/particle_plane_deflector_top.sv =====
// Top level of the particle plane deflector: config registers and pipeline glue.
//
//  channel | dir | payload
//  req     | in  | tdata: pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, time_step
//  rsp     | out | tdata: new_pos_x..z, new_vel_x..z; tuser: deflected
//  csr     | in  | addr: register index, wdata: value
//
// One transfer per cycle in each direction when neither side stalls.
// The path runs through 4 front stages, the queue, 31 divider stages
// and 3 output stages; the divider chain sets the depth.
// Front and back stall independently; the queue absorbs the difference.
// Reset clears valid state and loads register defaults.
module particle_plane_deflector_top #(
   parameter int QUEUE_DEPTH = ppd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, time_step, pad
   input  logic [223:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z
   output logic [191:0] rsp_tdata,
   // deflected
   output logic [0:0]   rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_addr,
   input  logic [31:0]  csr_wdata
);
   import ppd_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   logic [2:0][31:0] in_pos, in_vel, out_pos, out_vel;
   logic             f_valid, f_ready, q_valid, q_ready, out_hit;
   item_type         f_item, q_item;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_addr)
            REG_POINT_X:  cfg_in.point[0]  = csr_wdata;
            REG_POINT_Y:  cfg_in.point[1]  = csr_wdata;
            REG_POINT_Z:  cfg_in.point[2]  = csr_wdata;
            REG_NORMAL_X: cfg_in.normal[0] = csr_wdata[17:0];
            REG_NORMAL_Y: cfg_in.normal[1] = csr_wdata[17:0];
            REG_NORMAL_Z: cfg_in.normal[2] = csr_wdata[17:0];
            REG_BOUNCE:   cfg_in.bounce    = csr_wdata[16:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.point  <= '0;
         cfg_ff.normal <= {18'd0, 18'd65536, 18'd0};
         cfg_ff.bounce <= 17'd65536;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         in_pos[i] = req_tdata[32*i +: 32];
         in_vel[i] = req_tdata[96 + 32*i +: 32];
         rsp_tdata[32*i +: 32]      = out_pos[i];
         rsp_tdata[96 + 32*i +: 32] = out_vel[i];
      end
   end

   assign rsp_tuser[0] = out_hit;

   ppd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_pos    (in_pos),
      .in_vel    (in_vel),
      .in_tstep  (req_tdata[222:192]),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_item  (f_item)
   );

   ppd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_item  (f_item),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_item   (q_item)
   );

   ppd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_item   (q_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_pos   (out_pos),
      .out_vel   (out_vel),
      .out_hit   (out_hit)
   );

endmodule
